// ----- hdl/hsic_pkg.sv -----
// Shared types, constants and the hue ratio table for the HSI to RGB converter.
// No dependencies; imported by hsic_scale and hsi_to_rgb_converter_top.
package hsic_pkg;

  // Fixed-point formats
  localparam int INPUT_FRAC_BITS = 8;
  localparam int RATIO_FRAC_BITS = 14;

  // Field widths
  localparam int HUE_W   = 10;
  localparam int SAT_W   = 9;
  localparam int INT_W   = 10;
  localparam int LEVEL_W = 8;

  // Hue geometry
  localparam int HUE_FULL_DEG    = 360;
  localparam int HUE_HALF_DEG    = 180;
  localparam int SECTOR_DEG      = 120;
  localparam int HALF_SECTOR_DEG = 60;
  localparam int HUE_MOD_W       = $clog2(HUE_FULL_DEG);
  localparam int OFFSET_W        = $clog2(SECTOR_DEG);

  // Unit values of the input and ratio formats
  localparam int ONE_IN = 1 << INPUT_FRAC_BITS;
  localparam int ONE_R  = 1 << RATIO_FRAC_BITS;

  // Ratio lies in about -0.95..2.0: two integer bits plus sign
  localparam int RATIO_W  = RATIO_FRAC_BITS + 3;
  // Channel factor: up to 3.0 in Q22 (input plus ratio fraction bits) plus sign
  localparam int FACTOR_W = INPUT_FRAC_BITS + RATIO_FRAC_BITS + 3;

  // Channel gain 255/3 times intensity
  localparam int LEVEL_MAX   = 255;
  localparam int GAIN        = LEVEL_MAX / 3;
  localparam int GAIN_W      = $clog2(GAIN * 2 * ONE_IN + 1);
  localparam int PROD_W      = GAIN_W + FACTOR_W - 1;
  localparam int LEVEL_SHIFT = 2 * INPUT_FRAC_BITS + RATIO_FRAC_BITS;

  // Series constants for building the ratio table
  localparam int          TRIG_FRAC    = 28;
  localparam logic [63:0] PI_TRIG      = 64'd843314857;
  localparam int          SERIES_TERMS = 12;

  // Payload of one input beat and one result beat
  typedef struct packed {
    logic [HUE_W-1:0] hue_degrees;
    logic [SAT_W-1:0] saturation;
    logic [INT_W-1:0] intensity;
  } hsic_in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } hsic_out_t;

  // Hue sector: which channel gets which factor
  typedef enum logic [1:0] {
    SECT_RED_GREEN  = 2'd0,
    SECT_GREEN_BLUE = 2'd1,
    SECT_BLUE_RED   = 2'd2
  } hsic_sector_t;

  typedef logic signed [RATIO_W-1:0] hsic_ratio_tab_t [SECTOR_DEG];

  // Restoring division, elaboration only
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Cosine of deg degrees by Taylor series, TRIG_FRAC fraction bits
  function automatic logic signed [63:0] cos_deg(int deg);
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x    = (64'(deg) * PI_TRIG) / HUE_HALF_DEG;
    term = 64'd1 << TRIG_FRAC;
    sum  = $signed(term);
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      term = (term * x) >> TRIG_FRAC;
      term = udiv64((term * x) >> TRIG_FRAC, 64'((2 * k - 1) * (2 * k)));
      if (k % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    return sum;
  endfunction

  // cos(t)/cos(60-t), rounded half away from zero
  function automatic logic signed [63:0] ratio_entry(int t);
    logic signed [63:0] cn;
    logic signed [63:0] cd;
    int                 d;
    logic [63:0]        den;
    logic [63:0]        mag;
    logic [63:0]        q;
    cn = cos_deg(t);
    d  = (t <= HALF_SECTOR_DEG) ? (HALF_SECTOR_DEG - t) : (t - HALF_SECTOR_DEG);
    cd = cos_deg(d);
    if (cd <= 0) begin
      cd = 64'sd1;
    end
    den = cd;
    mag = (cn < 0) ? 64'(-cn) : 64'(cn);
    mag = mag << RATIO_FRAC_BITS;
    q   = udiv64(2 * mag + den, 2 * den);
    return (cn < 0) ? -$signed(q) : $signed(q);
  endfunction

  function automatic hsic_ratio_tab_t build_ratio_table();
    hsic_ratio_tab_t    tab;
    logic signed [63:0] e;
    for (int t = 0; t < SECTOR_DEG; t++) begin
      e      = ratio_entry(t);
      tab[t] = e[RATIO_W-1:0];
    end
    return tab;
  endfunction

  localparam hsic_ratio_tab_t RATIO_TABLE = build_ratio_table();

endpackage

// ----- hdl/hsic_scale.sv -----
// One channel of the output scaler: gain times factor, then scale down and clip.
// Depends on hsic_pkg for widths and the level shift.
module hsic_scale import hsic_pkg::*; (
  input  logic                  clk,
  input  logic [GAIN_W-1:0]     gain,
  input  logic [FACTOR_W-2:0]   factor,
  output logic [LEVEL_W-1:0]    level
);

  logic [PROD_W-1:0]             prod_r;
  logic [PROD_W-1:0]             prod_nxt;
  logic [PROD_W-LEVEL_SHIFT-1:0] whole;
  logic [LEVEL_W-1:0]            level_r;
  logic [LEVEL_W-1:0]            level_nxt;

  // Multiply gain by factor
  assign prod_nxt = PROD_W'(gain) * PROD_W'(factor);

  // Drop the fraction bits, clip at full scale
  assign whole     = prod_r[PROD_W-1:LEVEL_SHIFT];
  assign level_nxt = (whole > (PROD_W-LEVEL_SHIFT)'(LEVEL_MAX)) ?
                     LEVEL_W'(LEVEL_MAX) : whole[LEVEL_W-1:0];

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    level_r <= level_nxt;
  end

  assign level = level_r;

endmodule

// ----- hdl/hsi_to_rgb_converter_top.sv -----
// HSI to RGB converter top level: seven-stage pipeline with start/busy input.
// Depends on hsic_pkg and hsic_scale.
//
// Takes one hue/saturation/intensity color per clock and returns red, green
// and blue at the end of the pipeline, with out_valid high for
// exactly one cycle. busy is high only while in reset and on the first edge
// after it; once running, every cycle with start high takes a beat. The
// results cannot be held off, so a consumer must take every out_valid beat.
// Stages: hue wrap and clamps, sector split, ratio table and gain, channel
// factors, channel multiply, scale and clip, channel routing.
module hsi_to_rgb_converter_top import hsic_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  hsic_in_t  in_data,
  output logic      out_valid,
  output hsic_out_t out_data
);

  localparam int LATENCY = 7;

  logic busy_r;
  logic accept;

  // Valid bits per stage
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_valid_r;

  // Stage 1: wrapped hue, clamped saturation and intensity
  logic [HUE_MOD_W-1:0] hue1_r, hue1_nxt;
  logic [SAT_W-1:0]     sat1_r, sat1_nxt;
  logic [INT_W-1:0]     int1_r, int1_nxt;

  // Stage 2: sector and offset inside it
  hsic_sector_t         sec2_r, sec2_nxt;
  logic [OFFSET_W-1:0]  off2_r, off2_nxt;
  logic [SAT_W-1:0]     sat2_r;
  logic [INT_W-1:0]     int2_r;

  // Stage 3: ratio and gain
  hsic_sector_t               sec3_r;
  logic signed [RATIO_W-1:0]  ratio3_r;
  logic [SAT_W-1:0]           sat3_r;
  logic [GAIN_W-1:0]          gain3_r, gain3_nxt;

  // Stage 4: channel factors
  hsic_sector_t               sec4_r;
  logic [GAIN_W-1:0]          gain4_r;
  logic signed [FACTOR_W-1:0] sat_f, ratio_f, fa, fb, fc;
  logic [FACTOR_W-2:0]        fa4_r, fb4_r, fc4_r;

  // Stages 5 and 6 live in the scalers; carry the sector alongside
  hsic_sector_t               sec5_r, sec6_r;
  logic [LEVEL_W-1:0]         lvl_a, lvl_b, lvl_c;

  hsic_out_t                  out_r, out_nxt;

  function automatic logic [FACTOR_W-2:0] clip_neg(logic signed [FACTOR_W-1:0] f);
    return f[FACTOR_W-1] ? '0 : f[FACTOR_W-2:0];
  endfunction

  assign accept = start && !busy_r;

  // Wrap hue into 0..359, clamp saturation to 1.0 and intensity to 2.0
  always_comb begin
    if (in_data.hue_degrees >= HUE_W'(2 * HUE_FULL_DEG)) begin
      hue1_nxt = HUE_MOD_W'(in_data.hue_degrees - HUE_W'(2 * HUE_FULL_DEG));
    end else if (in_data.hue_degrees >= HUE_W'(HUE_FULL_DEG)) begin
      hue1_nxt = HUE_MOD_W'(in_data.hue_degrees - HUE_W'(HUE_FULL_DEG));
    end else begin
      hue1_nxt = HUE_MOD_W'(in_data.hue_degrees);
    end
    sat1_nxt = (in_data.saturation > SAT_W'(ONE_IN)) ? SAT_W'(ONE_IN) : in_data.saturation;
    int1_nxt = (in_data.intensity > INT_W'(2 * ONE_IN)) ? INT_W'(2 * ONE_IN) :
               in_data.intensity;
  end

  // Split hue into sector and offset
  always_comb begin
    if (hue1_r >= HUE_MOD_W'(2 * SECTOR_DEG)) begin
      sec2_nxt = SECT_BLUE_RED;
      off2_nxt = OFFSET_W'(hue1_r - HUE_MOD_W'(2 * SECTOR_DEG));
    end else if (hue1_r >= HUE_MOD_W'(SECTOR_DEG)) begin
      sec2_nxt = SECT_GREEN_BLUE;
      off2_nxt = OFFSET_W'(hue1_r - HUE_MOD_W'(SECTOR_DEG));
    end else begin
      sec2_nxt = SECT_RED_GREEN;
      off2_nxt = OFFSET_W'(hue1_r);
    end
  end

  // Gain is 255/3 times intensity
  assign gain3_nxt = GAIN_W'(int2_r) * GAIN_W'(GAIN);

  // Form the three channel factors
  assign sat_f   = $signed(FACTOR_W'(sat3_r));
  assign ratio_f = FACTOR_W'(ratio3_r);
  assign fa = FACTOR_W'(ONE_IN * ONE_R) + sat_f * ratio_f;
  assign fb = FACTOR_W'(ONE_IN * ONE_R) + sat_f * (FACTOR_W'(ONE_R) - ratio_f);
  assign fc = (FACTOR_W'(ONE_IN) - sat_f) <<< RATIO_FRAC_BITS;

  // Route channel levels by sector
  always_comb begin
    unique case (sec6_r)
      SECT_RED_GREEN: begin
        out_nxt.red = lvl_a; out_nxt.green = lvl_b; out_nxt.blue = lvl_c;
      end
      SECT_GREEN_BLUE: begin
        out_nxt.red = lvl_c; out_nxt.green = lvl_a; out_nxt.blue = lvl_b;
      end
      SECT_BLUE_RED: begin
        out_nxt.red = lvl_b; out_nxt.green = lvl_c; out_nxt.blue = lvl_a;
      end
      default: begin
        out_nxt = '0;
      end
    endcase
  end

  // Control: busy and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      v1_r        <= accept;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  // Payload: advance every cycle, the pipeline never stalls
  always_ff @(posedge clk) begin
    hue1_r   <= hue1_nxt;
    sat1_r   <= sat1_nxt;
    int1_r   <= int1_nxt;
    sec2_r   <= sec2_nxt;
    off2_r   <= off2_nxt;
    sat2_r   <= sat1_r;
    int2_r   <= int1_r;
    sec3_r   <= sec2_r;
    ratio3_r <= RATIO_TABLE[off2_r];
    sat3_r   <= sat2_r;
    gain3_r  <= gain3_nxt;
    sec4_r   <= sec3_r;
    gain4_r  <= gain3_r;
    fa4_r    <= clip_neg(fa);
    fb4_r    <= clip_neg(fb);
    fc4_r    <= clip_neg(fc);
    sec5_r   <= sec4_r;
    sec6_r   <= sec5_r;
    out_r    <= out_nxt;
  end

  hsic_scale u_scale_a (.clk(clk), .gain(gain4_r), .factor(fa4_r), .level(lvl_a));
  hsic_scale u_scale_b (.clk(clk), .gain(gain4_r), .factor(fb4_r), .level(lvl_b));
  hsic_scale u_scale_c (.clk(clk), .gain(gain4_r), .factor(fc4_r), .level(lvl_c));

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Every taken beat comes out as a valid result at the end of the pipeline
  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("taken beat did not come out");

  // No result without a matching taken beat
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a taken beat");

  // Zero saturation gives a gray: all channels equal
  a_gray: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(start && !busy && in_data.saturation == '0, LATENCY)) |->
    (out_data.red == out_data.green && out_data.green == out_data.blue))
    else $error("zero saturation gave unequal channels");

  // Zero intensity gives black
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(start && !busy && in_data.intensity == '0, LATENCY)) |->
    (out_data.red == '0 && out_data.green == '0 && out_data.blue == '0))
    else $error("zero intensity gave a nonzero channel");

endmodule

// ----- tb/hsi_to_rgb_converter_top_tb.sv -----
// Self-checking testbench for the HSI to RGB converter: start/busy stimulus, strobed results.
// Depends on hsic_pkg and hsi_to_rgb_converter_top; predicts each color with its own ratio math.
`timescale 1ns / 1ps

module hsi_to_rgb_converter_top_tb;
  import hsic_pkg::*;

  // Color math constants
  localparam int HUE_WRAP    = 360;
  localparam int SECTOR_SPAN = 120;
  localparam int HALF_SPAN   = 60;
  localparam int SAT_ONE     = 256;
  localparam int INT_TWO     = 512;
  localparam int RATIO_ONE   = 16384;
  localparam int RATIO_SHIFT = 14;
  localparam int COS_SHIFT   = 28;
  localparam int COS_TERMS   = 12;
  localparam int LEVEL_TOP   = 255;
  localparam int DROP_SHIFT  = 30;
  localparam logic [63:0] PI_Q28 = 64'd843314857;

  // Run shape
  localparam int RANDOM_COLORS = 1025;
  localparam int PHASE_LEN     = 350;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int TAIL_CYCLES   = 20;
  localparam int REPORT_MAX    = 10;

  typedef struct {
    hsic_in_t    beat;
    int unsigned idle_pct;
    bit          drain_first;
  } send_slot_t;

  typedef struct {
    hsic_in_t  beat;
    hsic_out_t rgb;
  } rgb_due_t;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  hsic_in_t  in_data = '0;
  logic      busy;
  logic      out_valid;
  hsic_out_t out_data;

  send_slot_t  colors_to_send[$];
  rgb_due_t    rgb_due[$];
  longint      ratio_q14[SECTOR_SPAN];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  hsi_to_rgb_converter_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Cosine of deg degrees by Taylor series, 28 fraction bits
  function automatic longint cos_q28(int unsigned deg);
    logic [63:0] x;
    logic [63:0] term;
    longint      sum;
    x    = (64'(deg) * PI_Q28) / 64'd180;
    term = 64'd1 << COS_SHIFT;
    sum  = longint'(term);
    for (int k = 1; k <= COS_TERMS; k++) begin
      term = (term * x) >> COS_SHIFT;
      term = ((term * x) >> COS_SHIFT) / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return sum;
  endfunction

  // floor(255 * I * F / 3) on the fixed-point codes, clipped to a level
  function automatic logic [7:0] channel_level(longint inten, longint factor);
    longint v;
    if (factor <= 0) begin
      return 8'd0;
    end
    v = (255 * inten * factor) / (longint'(3) << DROP_SHIFT);
    return (v > LEVEL_TOP) ? 8'd255 : v[7:0];
  endfunction

  // Expected red, green and blue for one color
  function automatic hsic_out_t hsi_to_rgb_predict(hsic_in_t c);
    int unsigned  hue;
    int unsigned  off;
    longint       sat;
    longint       inten;
    longint       r;
    longint       fa;
    longint       fb;
    longint       fc;
    logic [7:0]   la;
    logic [7:0]   lb;
    logic [7:0]   lc;
    hsic_sector_t sect;
    hsic_out_t    rgb;
    hue   = c.hue_degrees % HUE_WRAP;
    sat   = (c.saturation > SAT_ONE) ? SAT_ONE : c.saturation;
    inten = (c.intensity > INT_TWO) ? INT_TWO : c.intensity;
    sect  = hsic_sector_t'(hue / SECTOR_SPAN);
    off   = hue % SECTOR_SPAN;
    r     = ratio_q14[off];
    fa    = longint'(SAT_ONE) * RATIO_ONE + sat * r;
    fb    = longint'(SAT_ONE) * RATIO_ONE + sat * (RATIO_ONE - r);
    fc    = (SAT_ONE - sat) * RATIO_ONE;
    la    = channel_level(inten, fa);
    lb    = channel_level(inten, fb);
    lc    = channel_level(inten, fc);
    case (sect)
      SECT_RED_GREEN: begin
        rgb.red = la; rgb.green = lb; rgb.blue = lc;
      end
      SECT_GREEN_BLUE: begin
        rgb.red = lc; rgb.green = la; rgb.blue = lb;
      end
      default: begin
        rgb.red = lb; rgb.green = lc; rgb.blue = la;
      end
    endcase
    return rgb;
  endfunction

  // Queue one color; the idle rate follows the phase, drain at phase starts and at random
  task automatic add_color(int unsigned hue, int unsigned sat, int unsigned inten);
    send_slot_t  slot;
    int unsigned idx;
    idx                   = colors_to_send.size();
    slot.beat.hue_degrees = hue[HUE_W-1:0];
    slot.beat.saturation  = sat[SAT_W-1:0];
    slot.beat.intensity   = inten[INT_W-1:0];
    slot.idle_pct         = (idx < PHASE_LEN) ? 13 : (idx < 2 * PHASE_LEN) ? 69 : 0;
    slot.drain_first      = (idx == PHASE_LEN) || (idx == 2 * PHASE_LEN) ||
                            ($urandom_range(99) == 0);
    colors_to_send.push_back(slot);
  endtask

  // Drive beats from the pending queue; hold off a drain beat until all results are in
  always @(posedge clk) begin : drive
    logic go;
    if (!rst_n) begin
      start   <= 1'b0;
      in_data <= '0;
    end else begin
      if (start && !busy) begin
        void'(colors_to_send.pop_front());
      end
      go = 1'b0;
      if (colors_to_send.size() != 0) begin
        if (!colors_to_send[0].drain_first || (rgb_due.size() == 0 && !(start && !busy))) begin
          go = ($urandom_range(99) >= colors_to_send[0].idle_pct);
        end
      end
      start   <= go;
      in_data <= go ? colors_to_send[0].beat : hsic_in_t'($bits(hsic_in_t)'($urandom));
    end
  end

  // Check each result against the oldest prediction, then record new beats
  always @(posedge clk) begin : watch
    rgb_due_t due;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (rgb_due.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $display("%0t: result with nothing pending: r=%0d g=%0d b=%0d",
                     $realtime, out_data.red, out_data.green, out_data.blue);
          end
        end else begin
          due = rgb_due.pop_front();
          if (out_data.red !== due.rgb.red || out_data.green !== due.rgb.green ||
              out_data.blue !== due.rgb.blue) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
              $display("%0t: h=%0d s=%0d i=%0d expected r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                       $realtime, due.beat.hue_degrees, due.beat.saturation,
                       due.beat.intensity, due.rgb.red, due.rgb.green, due.rgb.blue,
                       out_data.red, out_data.green, out_data.blue);
            end
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        due.beat = in_data;
        due.rgb  = hsi_to_rgb_predict(in_data);
        rgb_due.push_back(due);
      end
    end
  end

  initial begin : stimulus
    longint      cn;
    longint      cd;
    logic [63:0] den;
    logic [63:0] mag;
    logic [63:0] q;
    int unsigned d;
    int unsigned hue;
    int unsigned sat;
    int unsigned inten;

    // Build the cos(t)/cos(60-t) ratios, rounded half away from zero
    for (int t = 0; t < SECTOR_SPAN; t++) begin
      cn = cos_q28(t);
      d  = (t <= HALF_SPAN) ? (HALF_SPAN - t) : (t - HALF_SPAN);
      cd = cos_q28(d);
      if (cd <= 0) begin
        cd = 1;
      end
      den = cd;
      mag = (cn < 0) ? -cn : cn;
      mag = mag << RATIO_SHIFT;
      q   = (2 * mag + den) / (2 * den);
      ratio_q14[t] = (cn < 0) ? -longint'(q) : longint'(q);
    end

    // Directed: sector edges, hue wrap, clamps and zero inputs
    add_color(0, 0, 0);
    add_color(0, 256, 512);
    add_color(119, 256, 512);
    add_color(120, 256, 512);
    add_color(239, 256, 512);
    add_color(240, 256, 512);
    add_color(359, 256, 512);
    add_color(360, 256, 512);
    add_color(720, 128, 256);
    add_color(1023, 511, 1023);
    add_color(60, 256, 512);
    add_color(180, 256, 300);
    add_color(300, 200, 512);
    add_color(90, 257, 513);
    add_color(30, 0, 512);
    add_color(200, 256, 0);
    add_color(45, 511, 1);
    add_color(1000, 100, 1023);
    add_color(0, 255, 511);
    add_color(600, 256, 512);
    add_color(100, 256, 512);
    add_color(110, 256, 1023);

    // Random: mostly in-range values, some clamped and wrapped ones
    for (int i = 0; i < RANDOM_COLORS; i++) begin
      hue   = ($urandom_range(9) < 6) ? $urandom_range(359) : $urandom_range(1023);
      sat   = ($urandom_range(9) < 7) ? $urandom_range(256) : $urandom_range(511);
      inten = ($urandom_range(9) < 7) ? $urandom_range(512) : $urandom_range(1023);
      add_color(hue, sat, inten);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every beat to go out and every result to come back
    while ((colors_to_send.size() != 0 || rgb_due.size() != 0 || start) &&
           cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
    end

    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk);
      if (fail_count == 0 && rgb_due.size() == 0) begin
        $display("CHECK OK");
      end else begin
        $display("CHECK FAILED");
      end
    end
    $finish;
  end

endmodule
